/* design/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES decrypt package
// Shared types, S-box inverse and GF helpers for the block decrypt core.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned MIN_ROUNDS = 10;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // a*9, a*11, a*13, a*14 from doublings
    function automatic logic [31:0] mul_set(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        return {a8 ^ a, a8 ^ a2 ^ a, a8 ^ a4 ^ a, a8 ^ a4 ^ a2};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [31:0] m0, m1, m2, m3;
        m0 = mul_set(c[31:24]);
        m1 = mul_set(c[23:16]);
        m2 = mul_set(c[15:8]);
        m3 = mul_set(c[7:0]);
        // fields: [31:24]=x9 [23:16]=x11 [15:8]=x13 [7:0]=x14
        return {m0[7:0] ^ m1[23:16] ^ m2[15:8] ^ m3[31:24],
                m0[31:24] ^ m1[7:0] ^ m2[23:16] ^ m3[15:8],
                m0[15:8] ^ m1[31:24] ^ m2[7:0] ^ m3[23:16],
                m0[23:16] ^ m1[15:8] ^ m2[31:24] ^ m3[7:0]};
    endfunction

    function automatic logic [7:0] byte_at(input t_block s, input int unsigned i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic t_block inv_shift_sub(input t_block s);
        t_block t;
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                t[127 - 8 * (row + 4 * col) -: 8] =
                    inv_sbox(byte_at(s, row + 4 * ((col + 4 - row) % 4)));
            end
        end
        return t;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block t;
        for (int col = 0; col < 4; col++) begin
            t[127 - 32 * col -: 32] = inv_mix_col(s[127 - 32 * col -: 32]);
        end
        return t;
    endfunction

endpackage

/* design/aes_if.sv */
// ----------------------------------------------------------------------------
// AES channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [4:0]  key_index;
    logic [63:0] key_value;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    modport source (output valid, action, key_index, key_value, cipher_high, cipher_low,
                    input ready);
    modport sink (input valid, action, key_index, key_value, cipher_high, cipher_low,
                  output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    modport source (output valid, plain_high, plain_low, input ready);
    modport sink (input valid, plain_high, plain_low, output ready);
endinterface

/* design/aes_round.sv */
// ----------------------------------------------------------------------------
// AES inverse round unit
// One shared round: AddRoundKey, optional InvMixColumns, then InvShiftRows+InvSubBytes unless i_last.
// ----------------------------------------------------------------------------
module aes_round (
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_key,
    input  logic            i_mix,
    input  logic            i_last,
    output aes_pkg::t_block o_state
);
    import aes_pkg::*;

    t_block w_add;
    t_block w_mix;

    always_comb begin
        w_add = i_state ^ i_key;
        w_mix = i_mix ? inv_mix(w_add) : w_add;
        o_state = i_last ? w_add : inv_shift_sub(w_mix);
    end
endmodule

/* design/aes_block_decrypt.sv */
// ----------------------------------------------------------------------------
// AES block decrypt
// Rounds iterate one round per cycle from accept until result valid.
// A new block is accepted only after the previous result is taken; key loads are accepted while idle.
// One shared round unit iterates; key halves are read from a two-word-wide store.
// Reset: synchronous active low; clears control and round count to 10, key store undefined.
// ----------------------------------------------------------------------------
module aes_block_decrypt #(
    parameter int unsigned MAX_ROUNDS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    aes_in_if.sink     i_in,
    aes_out_if.source  o_out
);
    import aes_pkg::*;

    localparam int unsigned SLOTS = 2 * (MAX_ROUNDS + 1);
    localparam int unsigned RW = $clog2(MAX_ROUNDS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state       r_state, n_state;
    logic [3:0]   r_nr;
    logic [RW-1:0] r_round;
    t_block       r_blk;
    logic [63:0]  r_mem_hi [MAX_ROUNDS+1];
    logic [63:0]  r_mem_lo [MAX_ROUNDS+1];
    t_block       r_key;
    logic         r_first;
    t_block       w_next;
    logic [RW-1:0] w_nr;
    logic [RW-1:0] w_rd;
    logic         w_acc;

    always_comb begin
        if (r_nr < 4'(MIN_ROUNDS)) w_nr = RW'(MIN_ROUNDS);
        else if (32'(r_nr) > MAX_ROUNDS) w_nr = RW'(MAX_ROUNDS);
        else w_nr = RW'(r_nr);
    end

    assign w_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // read address: the round after current while running, else Nr
    assign w_rd = (r_state == S_RUN && r_round != '0) ? r_round - RW'(1) : w_nr;

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_in.action && 32'(i_in.key_index) < SLOTS) begin
            if (i_in.key_index[0]) r_mem_lo[i_in.key_index[4:1]] <= i_in.key_value;
            else r_mem_hi[i_in.key_index[4:1]] <= i_in.key_value;
        end
        r_key <= {r_mem_hi[w_rd], r_mem_lo[w_rd]};
    end

    aes_round u_round (
        .i_state (r_blk),
        .i_key   (r_key),
        .i_mix   (!r_first),
        .i_last  (r_round == '0),
        .o_state (w_next)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc && i_in.action) n_state = S_RUN;
            S_RUN:  if (r_round == '0) n_state = S_OUT;
            S_OUT:  if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nr    <= 4'(MIN_ROUNDS);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_nr <= i_cfg_data;
        end
        if (r_state == S_IDLE) begin
            r_blk   <= {i_in.cipher_high, i_in.cipher_low};
            r_round <= w_nr;
            r_first <= 1'b1;
        end else if (r_state == S_RUN) begin
            r_blk   <= w_next;
            r_round <= r_round - RW'(1);
            r_first <= 1'b0;
        end
    end

    assign o_out.valid      = (r_state == S_OUT);
    assign o_out.plain_high = r_blk[127:64];
    assign o_out.plain_low  = r_blk[63:0];
endmodule

/* design/aes_block_decrypt_checker.sv */
// ----------------------------------------------------------------------------
// AES block decrypt checker
// Port-level properties of the decrypt block, bound into aes_block_decrypt.
// ----------------------------------------------------------------------------
module aes_block_decrypt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_high
);
    ap_no_ready_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("ready while result pending");
    ap_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_in_action) |=> !i_out_valid)
        else $error("load produced result");
    ap_decrypt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_action) |=> !i_in_ready)
        else $error("ready during decrypt");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_high)))
        else $error("result dropped");
endmodule

bind aes_block_decrypt aes_block_decrypt_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_high  (o_out.plain_high)
);
